// File: rtl/ltg_pkg.sv
// shared types and constants for the toroidal life grid block
// used by the request interface, the head unit and the top level
`default_nettype none

package ltg_pkg;

	localparam int ROWS_DEF = 32;
	localparam int COLS_DEF = 32;

	// fixed request field widths
	localparam int OP_W  = 2;
	localparam int ROW_W = 5;
	localparam int COL_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_STEP  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// request as held while the rows pass by the head unit
	typedef struct packed {
		op_t              operation;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             value;
	} cmd_t;

	// per-cycle control from the sequencer to the head unit
	typedef struct packed {
		op_t              operation;
		logic [COL_W-1:0] col;
		logic             value;
		logic             row_hit;
	} head_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/ltg_op_if.sv
// request channel of the life grid block: valid/ready plus operation fields
// depends on ltg_pkg for the field widths
`default_nettype none

interface ltg_op_if;
	logic                      valid;
	logic                      ready;
	logic [ltg_pkg::OP_W-1:0]  operation;
	logic [ltg_pkg::ROW_W-1:0] row;
	logic [ltg_pkg::COL_W-1:0] col;
	logic                      value;

	modport source (output valid, operation, row, col, value, input ready);
	modport sink   (input valid, operation, row, col, value, output ready);
endinterface

`default_nettype wire

// File: rtl/ltg_res_if.sv
// result channel of the life grid block: valid/ready plus the read cell value
// no dependencies
`default_nettype none

interface ltg_res_if;
	logic valid;
	logic ready;
	logic cell_value;

	modport source (output valid, cell_value, input ready);
	modport sink   (input valid, cell_value, output ready);
endinterface

`default_nettype wire

// File: rtl/ltg_row_cell.sv
// one link of the row chain: holds one grid row, takes its neighbor's row on shift
// no package dependencies
`default_nettype none

module ltg_row_cell #(
	parameter int COLS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift_en,
	input  wire logic [COLS-1:0] d,
	output logic      [COLS-1:0] q
);

	logic [COLS-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift_en) begin
			row_q <= d;
		end
	end

	assign q = row_q;

endmodule

`default_nettype wire

// File: rtl/ltg_head.sv
// head unit at the end of the row chain: life rule, cell write, clear and read tap
// depends on ltg_pkg for head_ctrl_t and op_t
`default_nettype none

module ltg_head #(
	parameter int COLS = 32
) (
	input  wire ltg_pkg::head_ctrl_t ctrl,
	input  wire logic [COLS-1:0]     up,
	input  wire logic [COLS-1:0]     cur,
	input  wire logic [COLS-1:0]     dn,
	output logic      [COLS-1:0]     new_row,
	output logic                     rd_bit
);

	localparam int CIW   = $clog2(COLS);
	localparam int CMP_W = ((CIW > ltg_pkg::COL_W) ? CIW : ltg_pkg::COL_W) + 1;

	logic [COLS-1:0] life_row;
	logic [COLS-1:0] col_hit;

	for (genvar c = 0; c < COLS; c++) begin : g_col
		localparam int LF = (c + COLS - 1) % COLS;
		localparam int RT = (c + 1) % COLS;
		logic [3:0] n;

		assign n = {3'd0, up[LF]} + {3'd0, up[c]} + {3'd0, up[RT]}
			+ {3'd0, cur[LF]} + {3'd0, cur[RT]}
			+ {3'd0, dn[LF]} + {3'd0, dn[c]} + {3'd0, dn[RT]};
		// birth on three, survival on two or three
		assign life_row[c] = (n == 4'd3) || ((n == 4'd2) && cur[c]);
		assign col_hit[c]  = (CMP_W'(ctrl.col) == CMP_W'(c));
	end

	always_comb begin
		new_row = cur;
		case (ctrl.operation)
			ltg_pkg::OP_STEP: begin
				new_row = life_row;
			end
			ltg_pkg::OP_CLEAR: begin
				new_row = '0;
			end
			ltg_pkg::OP_WRITE: begin
				if (ctrl.row_hit) begin
					new_row = (cur & ~col_hit) | ({COLS{ctrl.value}} & col_hit);
				end
			end
			default: begin
				new_row = cur;
			end
		endcase
	end

	// column out of range leaves col_hit empty, so the read gives zero
	assign rd_bit = |(cur & col_hit);

endmodule

`default_nettype wire

// File: rtl/life_torus_generation_step.sv
// Life grid (B3/S23) on a ROWS x COLS torus. The grid sits in a circular chain of
// ROWS row cells; every request (write, read, step, clear) rotates the whole chain
// once past a head unit that rewrites one row per cycle. The next request is only
// taken after the rotation ends and the result is loaded. One result comes back
// per request; a new request is taken while the previous result still waits in
// the output register.
// depends on ltg_pkg, ltg_op_if, ltg_res_if, ltg_row_cell, ltg_head
`default_nettype none

module life_torus_generation_step #(
	parameter int ROWS = ltg_pkg::ROWS_DEF,
	parameter int COLS = ltg_pkg::COLS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ltg_op_if.sink     op,
	ltg_res_if.source  res
);

	localparam int RIW   = $clog2(ROWS);
	localparam int CMP_W = ((RIW > ltg_pkg::ROW_W) ? RIW : ltg_pkg::ROW_W) + 1;

	ltg_pkg::state_t    state_q, state_d;
	ltg_pkg::cmd_t      cmd_q;
	ltg_pkg::head_ctrl_t ctrl;
	logic [RIW-1:0]     cnt_q;
	logic [COLS-1:0]    prev_q;
	logic [COLS-1:0]    first_q;
	logic               rd_q;
	logic               res_valid_q;
	logic               res_value_q;

	logic               accept;
	logic               shift_en;
	logic               res_load;
	logic               last;
	logic [COLS-1:0]    cell_row [ROWS];
	logic [COLS-1:0]    head_row;
	logic [COLS-1:0]    dn_row;
	logic               rd_bit;

	// row chain: cell 0 is the head position, the new row enters at the far end
	for (genvar k = 0; k < ROWS; k++) begin : g_cell
		if (k == ROWS - 1) begin : g_tail
			ltg_row_cell #(.COLS(COLS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (head_row),
				.q        (cell_row[k])
			);
		end else begin : g_body
			ltg_row_cell #(.COLS(COLS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (cell_row[k+1]),
				.q        (cell_row[k])
			);
		end
	end

	assign last   = (cnt_q == RIW'(ROWS - 1));
	// on the last row the row below is old row 0, already replaced in the chain
	assign dn_row = last ? first_q : cell_row[1];

	assign ctrl.operation = cmd_q.operation;
	assign ctrl.col       = cmd_q.col;
	assign ctrl.value     = cmd_q.value;
	assign ctrl.row_hit   = (CMP_W'(cmd_q.row) == CMP_W'(cnt_q));

	ltg_head #(.COLS(COLS)) u_head (
		.ctrl    (ctrl),
		.up      (prev_q),
		.cur     (cell_row[0]),
		.dn      (dn_row),
		.new_row (head_row),
		.rd_bit  (rd_bit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ltg_pkg::ST_IDLE: begin
				if (op.valid) state_d = ltg_pkg::ST_RUN;
			end
			ltg_pkg::ST_RUN: begin
				if (last) state_d = ltg_pkg::ST_DONE;
			end
			ltg_pkg::ST_DONE: begin
				if (!res_valid_q || res.ready) state_d = ltg_pkg::ST_IDLE;
			end
			default: begin
				state_d = ltg_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		op.ready = 1'b0;
		shift_en = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ltg_pkg::ST_IDLE: op.ready = 1'b1;
			ltg_pkg::ST_RUN:  shift_en = 1'b1;
			ltg_pkg::ST_DONE: res_load = !res_valid_q || res.ready;
			default: begin
				op.ready = 1'b0;
			end
		endcase
	end

	assign accept = op.valid && op.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ltg_pkg::ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (shift_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.operation <= ltg_pkg::op_t'(op.operation);
			cmd_q.row       <= op.row;
			cmd_q.col       <= op.col;
			cmd_q.value     <= op.value;
			prev_q          <= cell_row[ROWS-1];
			first_q         <= cell_row[0];
			rd_q            <= 1'b0;
		end else if (shift_en) begin
			prev_q <= cell_row[0];
			if (cmd_q.operation == ltg_pkg::OP_READ && ctrl.row_hit) begin
				rd_q <= rd_bit;
			end
		end
		if (res_load) begin
			res_value_q <= rd_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.cell_value = res_value_q;

endmodule

`default_nettype wire
